// ===== rtl/core/pgc_pkg.sv =====
// pgc_pkg: types, constants and stop tables of the palette gradient color block
// used by the stream interface instances and by palette_gradient_color
// no dependencies
package pgc_pkg;

  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 4;

  localparam int ROM_PALETTES = 16;
  localparam int ROM_IDX_W    = $clog2(ROM_PALETTES);
  localparam int ROM_STOPS    = 5;
  localparam int STOP_IDX_W   = $clog2(ROM_STOPS);
  localparam int STOP_CNT_W   = $clog2(ROM_STOPS + 1);

  // f = (delta*255 * recip) >> RECIP_SHIFT, exact for delta*255 < 2^16 and span < 2^8
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int NUM_W       = 16;
  localparam int FPROD_W     = NUM_W + RECIP_W;

  localparam logic [7:0] PAL_RAINBOW = 8'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PALETTE_SELECT = 4'd0,
    CFG_PRIMARY_RED    = 4'd1,
    CFG_PRIMARY_GREEN  = 4'd2,
    CFG_PRIMARY_BLUE   = 4'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    HUE_R_TO_Y = 3'd0,
    HUE_Y_TO_G = 3'd1,
    HUE_G_TO_C = 3'd2,
    HUE_C_TO_B = 3'd3,
    HUE_B_TO_M = 3'd4,
    HUE_M_TO_R = 3'd5
  } hue_region_e;

  typedef struct packed {
    logic [7:0] position;
  } pos_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_item_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic [7:0] pos;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } stop_t;

  typedef logic [STOP_CNT_W-1:0] stop_cnt_rom_t [ROM_PALETTES];
  typedef stop_t stop_rom_t [ROM_PALETTES][ROM_STOPS];
  typedef logic [RECIP_W-1:0] recip_rom_t [ROM_PALETTES][ROM_STOPS-1];

  localparam stop_cnt_rom_t STOP_COUNT = '{
    3'd0, 3'd0, 3'd5, 3'd4, 3'd4, 3'd4, 3'd5, 3'd5,
    3'd5, 3'd5, 3'd4, 3'd4, 3'd5, 3'd4, 3'd4, 3'd4
  };

  localparam stop_rom_t STOP_ROM = '{
    '{'{8'd0, 8'd0, 8'd0, 8'd0}, '{8'd0, 8'd0, 8'd0, 8'd0}, '{8'd0, 8'd0, 8'd0, 8'd0},
      '{8'd0, 8'd0, 8'd0, 8'd0}, '{8'd0, 8'd0, 8'd0, 8'd0}},
    '{'{8'd0, 8'd0, 8'd0, 8'd0}, '{8'd0, 8'd0, 8'd0, 8'd0}, '{8'd0, 8'd0, 8'd0, 8'd0},
      '{8'd0, 8'd0, 8'd0, 8'd0}, '{8'd0, 8'd0, 8'd0, 8'd0}},
    '{'{8'd0, 8'd255, 8'd0, 8'd128}, '{8'd64, 8'd255, 8'd100, 8'd0},
      '{8'd128, 8'd255, 8'd220, 8'd0}, '{8'd192, 8'd180, 8'd0, 8'd255},
      '{8'd255, 8'd255, 8'd0, 8'd128}},
    '{'{8'd0, 8'd0, 8'd20, 8'd90}, '{8'd80, 8'd0, 8'd90, 8'd160},
      '{8'd160, 8'd0, 8'd170, 8'd190}, '{8'd255, 8'd190, 8'd240, 8'd255},
      '{8'd0, 8'd0, 8'd0, 8'd0}},
    '{'{8'd0, 8'd0, 8'd40, 8'd10}, '{8'd90, 8'd20, 8'd110, 8'd20},
      '{8'd170, 8'd90, 8'd160, 8'd30}, '{8'd255, 8'd200, 8'd220, 8'd90},
      '{8'd0, 8'd0, 8'd0, 8'd0}},
    '{'{8'd0, 8'd20, 8'd0, 8'd0}, '{8'd90, 8'd160, 8'd20, 8'd0},
      '{8'd180, 8'd255, 8'd110, 8'd0}, '{8'd255, 8'd255, 8'd230, 8'd120},
      '{8'd0, 8'd0, 8'd0, 8'd0}},
    '{'{8'd0, 8'd0, 8'd0, 8'd80}, '{8'd60, 8'd0, 8'd60, 8'd160},
      '{8'd130, 8'd120, 8'd160, 8'd220}, '{8'd200, 8'd220, 8'd235, 8'd255},
      '{8'd255, 8'd255, 8'd255, 8'd255}},
    '{'{8'd0, 8'd0, 8'd0, 8'd0}, '{8'd64, 8'd140, 8'd0, 8'd0},
      '{8'd128, 8'd220, 8'd60, 8'd0}, '{8'd190, 8'd255, 8'd190, 8'd0},
      '{8'd255, 8'd255, 8'd255, 8'd220}},
    '{'{8'd0, 8'd60, 8'd10, 8'd60}, '{8'd70, 8'd200, 8'd50, 8'd60},
      '{8'd140, 8'd255, 8'd120, 8'd40}, '{8'd200, 8'd255, 8'd190, 8'd90},
      '{8'd255, 8'd255, 8'd235, 8'd180}},
    '{'{8'd0, 8'd0, 8'd20, 8'd40}, '{8'd70, 8'd0, 8'd140, 8'd110},
      '{8'd140, 8'd40, 8'd220, 8'd150}, '{8'd200, 8'd120, 8'd90, 8'd220},
      '{8'd255, 8'd20, 8'd20, 8'd90}},
    '{'{8'd0, 8'd0, 8'd10, 8'd60}, '{8'd80, 8'd0, 8'd90, 8'd180},
      '{8'd160, 8'd120, 8'd200, 8'd240}, '{8'd255, 8'd255, 8'd255, 8'd255},
      '{8'd0, 8'd0, 8'd0, 8'd0}},
    '{'{8'd0, 8'd60, 8'd10, 8'd0}, '{8'd90, 8'd180, 8'd60, 8'd0},
      '{8'd170, 8'd255, 8'd140, 8'd30}, '{8'd255, 8'd255, 8'd200, 8'd120},
      '{8'd0, 8'd0, 8'd0, 8'd0}},
    '{'{8'd0, 8'd60, 8'd15, 8'd0}, '{8'd80, 8'd170, 8'd60, 8'd0},
      '{8'd160, 8'd220, 8'd140, 8'd20}, '{8'd220, 8'd200, 8'd90, 8'd10},
      '{8'd255, 8'd120, 8'd30, 8'd0}},
    '{'{8'd0, 8'd120, 8'd20, 8'd60}, '{8'd80, 8'd255, 8'd120, 8'd180},
      '{8'd160, 8'd255, 8'd190, 8'd215}, '{8'd255, 8'd255, 8'd240, 8'd245},
      '{8'd0, 8'd0, 8'd0, 8'd0}},
    '{'{8'd0, 8'd0, 8'd255, 8'd200}, '{8'd85, 8'd80, 8'd0, 8'd255},
      '{8'd170, 8'd255, 8'd0, 8'd150}, '{8'd255, 8'd0, 8'd255, 8'd200},
      '{8'd0, 8'd0, 8'd0, 8'd0}},
    '{'{8'd0, 8'd0, 8'd0, 8'd30}, '{8'd90, 8'd0, 8'd40, 8'd110},
      '{8'd170, 8'd0, 8'd120, 8'd150}, '{8'd255, 8'd80, 8'd220, 8'd200},
      '{8'd0, 8'd0, 8'd0, 8'd0}}
  };

  // ceil(2^shift / span) for every span that occurs between adjacent stops
  localparam int RECIP_ONE = 1 << RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] RCP_NONE    = '0;
  localparam logic [RECIP_W-1:0] RCP_SPAN_35 = RECIP_W'((RECIP_ONE + 34) / 35);
  localparam logic [RECIP_W-1:0] RCP_SPAN_55 = RECIP_W'((RECIP_ONE + 54) / 55);
  localparam logic [RECIP_W-1:0] RCP_SPAN_60 = RECIP_W'((RECIP_ONE + 59) / 60);
  localparam logic [RECIP_W-1:0] RCP_SPAN_62 = RECIP_W'((RECIP_ONE + 61) / 62);
  localparam logic [RECIP_W-1:0] RCP_SPAN_63 = RECIP_W'((RECIP_ONE + 62) / 63);
  localparam logic [RECIP_W-1:0] RCP_SPAN_64 = RECIP_W'((RECIP_ONE + 63) / 64);
  localparam logic [RECIP_W-1:0] RCP_SPAN_65 = RECIP_W'((RECIP_ONE + 64) / 65);
  localparam logic [RECIP_W-1:0] RCP_SPAN_70 = RECIP_W'((RECIP_ONE + 69) / 70);
  localparam logic [RECIP_W-1:0] RCP_SPAN_75 = RECIP_W'((RECIP_ONE + 74) / 75);
  localparam logic [RECIP_W-1:0] RCP_SPAN_80 = RECIP_W'((RECIP_ONE + 79) / 80);
  localparam logic [RECIP_W-1:0] RCP_SPAN_85 = RECIP_W'((RECIP_ONE + 84) / 85);
  localparam logic [RECIP_W-1:0] RCP_SPAN_90 = RECIP_W'((RECIP_ONE + 89) / 90);
  localparam logic [RECIP_W-1:0] RCP_SPAN_95 = RECIP_W'((RECIP_ONE + 94) / 95);

  // one entry per adjacent stop pair of STOP_ROM, zero where the palette has no such pair
  localparam recip_rom_t RECIP_ROM = '{
    '{RCP_NONE,    RCP_NONE,    RCP_NONE,    RCP_NONE},
    '{RCP_NONE,    RCP_NONE,    RCP_NONE,    RCP_NONE},
    '{RCP_SPAN_64, RCP_SPAN_64, RCP_SPAN_64, RCP_SPAN_63},
    '{RCP_SPAN_80, RCP_SPAN_80, RCP_SPAN_95, RCP_NONE},
    '{RCP_SPAN_90, RCP_SPAN_80, RCP_SPAN_85, RCP_NONE},
    '{RCP_SPAN_90, RCP_SPAN_90, RCP_SPAN_75, RCP_NONE},
    '{RCP_SPAN_60, RCP_SPAN_70, RCP_SPAN_70, RCP_SPAN_55},
    '{RCP_SPAN_64, RCP_SPAN_64, RCP_SPAN_62, RCP_SPAN_65},
    '{RCP_SPAN_70, RCP_SPAN_70, RCP_SPAN_60, RCP_SPAN_55},
    '{RCP_SPAN_70, RCP_SPAN_70, RCP_SPAN_60, RCP_SPAN_55},
    '{RCP_SPAN_80, RCP_SPAN_80, RCP_SPAN_95, RCP_NONE},
    '{RCP_SPAN_90, RCP_SPAN_80, RCP_SPAN_85, RCP_NONE},
    '{RCP_SPAN_80, RCP_SPAN_80, RCP_SPAN_60, RCP_SPAN_35},
    '{RCP_SPAN_80, RCP_SPAN_80, RCP_SPAN_95, RCP_NONE},
    '{RCP_SPAN_85, RCP_SPAN_85, RCP_SPAN_85, RCP_NONE},
    '{RCP_SPAN_90, RCP_SPAN_80, RCP_SPAN_85, RCP_NONE}
  };

  // (255 * x) >> 8
  function automatic logic [7:0] mul255_shr8(logic [7:0] x);
    logic [15:0] w;
    w = {x, 8'd0} - {8'd0, x};
    return w[15:8];
  endfunction

endpackage

// ===== rtl/core/pgc_stream_if.sv =====
// pgc_stream_if: valid/ready stream channel with a typed payload
// payload type is set per instance, usually from pgc_pkg
interface pgc_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

// ===== rtl/core/palette_gradient_color.sv =====
// palette_gradient_color: palette position to rgb color, four-stage pipeline
// depends on pgc_pkg (types, stop and reciprocal tables) and pgc_stream_if
//
//   channel   dir  payload              accepted when
//   in_i      in   position             in_i.valid && in_i.ready
//   out_o     out  red, green, blue     out_o.valid && out_o.ready
//   cfg_*     in   index, 8-bit data    cfg_we_i
//
// one item per clock sustained while out_o.ready holds; stages: bracket search, reciprocal
// multiply for the blend factor, channel blend products, divide by 255
// each stage has its own ready, so bubbles close up while the output stalls
// reset clears the stage valid bits and the four config registers
module palette_gradient_color #(
  parameter int PALETTE_COUNT = 16,
  parameter int MAX_STOPS     = 5
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pgc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pgc_pkg::CFG_W-1:0]     cfg_wdata_i,
  pgc_stream_if.sink                   in_i,
  pgc_stream_if.source                 out_o
);
  import pgc_pkg::*;

  // config registers
  logic [7:0] pal_q;
  rgb_t       prim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_q  <= '0;
      prim_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_PALETTE_SELECT: pal_q    <= cfg_wdata_i;
        CFG_PRIMARY_RED:    prim_q.r <= cfg_wdata_i;
        CFG_PRIMARY_GREEN:  prim_q.g <= cfg_wdata_i;
        CFG_PRIMARY_BLUE:   prim_q.b <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // per-stage handshake
  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !s4_valid_q || out_o.ready;
  assign rdy3 = !s3_valid_q || rdy4;
  assign rdy2 = !s2_valid_q || rdy3;
  assign rdy1 = !s1_valid_q || rdy2;
  assign in_i.ready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      if (rdy1) s1_valid_q <= in_i.valid;
      if (rdy2) s2_valid_q <= s1_valid_q;
      if (rdy3) s3_valid_q <= s2_valid_q;
      if (rdy4) s4_valid_q <= s3_valid_q;
    end
  end

  // stage 1: mode, bracket search, hue region
  logic                      rb_d;
  hue_region_e               region_d;
  logic [7:0]                rem_d;
  rgb_t                      ca_d, cb_d;
  logic [7:0]                delta_d;
  logic [RECIP_W-1:0]        recip_d;

  logic [7:0]                pos;
  logic                      in_rom;
  logic [ROM_IDX_W-1:0]      pal_idx;
  logic [STOP_CNT_W-1:0]     n_stops;
  logic                      found;
  logic [7:0]                hue_base;
  logic [7:0]                hue_diff;
  stop_t                     sa, sb;

  assign pos     = in_i.data.position;
  assign pal_idx = pal_q[ROM_IDX_W-1:0];

  always_comb begin
    rb_d   = (pal_q == PAL_RAINBOW);
    in_rom = ({1'b0, pal_q} < 9'(PALETTE_COUNT)) && (pal_q < 8'(ROM_PALETTES));
    n_stops = in_rom ? STOP_COUNT[pal_idx] : '0;
    if (int'(n_stops) > MAX_STOPS) n_stops = STOP_CNT_W'(MAX_STOPS);

    // primary color and single-stop results ride through the blend with f = 0
    ca_d    = prim_q;
    cb_d    = prim_q;
    delta_d = '0;
    recip_d = '0;
    found   = 1'b0;
    sa      = '0;
    sb      = '0;
    if (n_stops != '0) begin
      sa   = STOP_ROM[pal_idx][STOP_IDX_W'(n_stops - STOP_CNT_W'(1))];
      ca_d = '{r: sa.r, g: sa.g, b: sa.b};
      cb_d = ca_d;
      for (int i = 0; i < ROM_STOPS - 1; i++) begin
        if (!found && ((i + 1) < int'(n_stops)) &&
            (pos >= STOP_ROM[pal_idx][i].pos) && (pos <= STOP_ROM[pal_idx][i+1].pos)) begin
          found   = 1'b1;
          sa      = STOP_ROM[pal_idx][i];
          sb      = STOP_ROM[pal_idx][i+1];
          ca_d    = '{r: sa.r, g: sa.g, b: sa.b};
          cb_d    = '{r: sb.r, g: sb.g, b: sb.b};
          delta_d = pos - sa.pos;
          // an empty span gives a zero delta, which returns the left stop
          recip_d = RECIP_ROM[pal_idx][i];
        end
      end
    end

    // hue / 43 by compares
    if (pos >= 8'd215) begin
      region_d = HUE_M_TO_R;
      hue_base = 8'd215;
    end else if (pos >= 8'd172) begin
      region_d = HUE_B_TO_M;
      hue_base = 8'd172;
    end else if (pos >= 8'd129) begin
      region_d = HUE_C_TO_B;
      hue_base = 8'd129;
    end else if (pos >= 8'd86) begin
      region_d = HUE_G_TO_C;
      hue_base = 8'd86;
    end else if (pos >= 8'd43) begin
      region_d = HUE_Y_TO_G;
      hue_base = 8'd43;
    end else begin
      region_d = HUE_R_TO_Y;
      hue_base = 8'd0;
    end
    hue_diff = pos - hue_base;
    rem_d    = 8'(hue_diff * 8'd6);
  end

  logic               rb1_q;
  hue_region_e        region1_q;
  logic [7:0]         rem1_q;
  rgb_t               ca1_q, cb1_q;
  logic [7:0]         delta1_q;
  logic [RECIP_W-1:0] recip1_q;

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      rb1_q     <= rb_d;
      region1_q <= region_d;
      rem1_q    <= rem_d;
      ca1_q     <= ca_d;
      cb1_q     <= cb_d;
      delta1_q  <= delta_d;
      recip1_q  <= recip_d;
    end
  end

  // stage 2: blend factor by reciprocal multiply, first rainbow product
  logic [NUM_W-1:0]   num;
  logic [FPROD_W-1:0] f_prod;

  assign num    = {delta1_q, 8'd0} - {8'd0, delta1_q};
  assign f_prod = FPROD_W'(num) * FPROD_W'(recip1_q);

  logic        rb2_q;
  hue_region_e region2_q;
  logic [7:0]  q1_2_q, t1_2_q;
  rgb_t        ca2_q, cb2_q;
  logic [7:0]  f2_q;

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      rb2_q     <= rb1_q;
      region2_q <= region1_q;
      q1_2_q    <= mul255_shr8(rem1_q);
      t1_2_q    <= mul255_shr8(~rem1_q);
      ca2_q     <= ca1_q;
      cb2_q     <= cb1_q;
      f2_q      <= f_prod[RECIP_SHIFT +: 8];
    end
  end

  // stage 3: channel blend sums, second rainbow product
  logic [7:0] f2_inv;
  assign f2_inv = ~f2_q;

  logic        rb3_q;
  hue_region_e region3_q;
  logic [7:0]  q3_q, t3_q;
  logic [15:0] vr3_q, vg3_q, vb3_q;

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      rb3_q     <= rb2_q;
      region3_q <= region2_q;
      q3_q      <= mul255_shr8(~q1_2_q);
      t3_q      <= mul255_shr8(~t1_2_q);
      vr3_q     <= 16'(ca2_q.r) * 16'(f2_inv) + 16'(cb2_q.r) * 16'(f2_q);
      vg3_q     <= 16'(ca2_q.g) * 16'(f2_inv) + 16'(cb2_q.g) * 16'(f2_q);
      vb3_q     <= 16'(ca2_q.b) * 16'(f2_inv) + 16'(cb2_q.b) * 16'(f2_q);
    end
  end

  // stage 4: divide by 255 and rainbow channel select
  function automatic logic [7:0] div255(logic [15:0] v);
    logic [32:0] p;
    p = 33'(v) * 33'(17'h8081);
    return p[30:23];
  endfunction

  color_item_t out_d, out_q;

  always_comb begin
    if (rb3_q) begin
      case (region3_q)
        HUE_R_TO_Y: out_d = '{red: 8'd255, green: t3_q,   blue: 8'd0};
        HUE_Y_TO_G: out_d = '{red: q3_q,   green: 8'd255, blue: 8'd0};
        HUE_G_TO_C: out_d = '{red: 8'd0,   green: 8'd255, blue: t3_q};
        HUE_C_TO_B: out_d = '{red: 8'd0,   green: q3_q,   blue: 8'd255};
        HUE_B_TO_M: out_d = '{red: t3_q,   green: 8'd0,   blue: 8'd255};
        default:    out_d = '{red: 8'd255, green: 8'd0,   blue: q3_q};
      endcase
    end else begin
      out_d = '{red: div255(vr3_q), green: div255(vg3_q), blue: div255(vb3_q)};
    end
  end

  logic rb4_q;

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      out_q <= out_d;
      rb4_q <= rb3_q;
    end
  end

  assign out_o.valid = s4_valid_q;
  assign out_o.data  = out_q;

  // assertions
  a_bubble_takes_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_i.ready)
    else $error("input stalled while the first stage is empty");

  a_accept_fills_stage1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> s1_valid_q)
    else $error("accepted item did not enter the first stage");

  a_blend_factor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !rb1_q) |-> (f_prod[FPROD_W-1:RECIP_SHIFT+8] == '0))
    else $error("blend factor overflows eight bits");

  a_rainbow_full_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s4_valid_q && rb4_q) |->
      (out_q.red == 8'd255 || out_q.green == 8'd255 || out_q.blue == 8'd255))
    else $error("rainbow color without a full channel");

endmodule

// ===== tb/sv/pgc_color_checker.sv =====
// pgc_color_checker: watches the position and color channels of palette_gradient_color,
// predicts every color from its own copy of the palette tables and compares in order
// depends on pgc_pkg for the item types, register codes and hue region names
`timescale 1ns / 100ps

module pgc_color_checker #(
  parameter int PALETTE_COUNT = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pgc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pgc_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          pos_valid_i,
  input  logic                          pos_ready_i,
  input  pgc_pkg::pos_item_t            pos_i,
  input  logic                          color_valid_i,
  input  logic                          color_ready_i,
  input  pgc_pkg::color_item_t          color_i,
  output int                            pending_o,
  output int                            errors_o
);
  import pgc_pkg::*;

  // gradient stops per palette, packed as {pos, r, g, b}
  localparam int GRAD_STOP_CNT [16] = '{0, 0, 5, 4, 4, 4, 5, 5, 5, 5, 4, 4, 5, 4, 4, 4};

  localparam logic [31:0] GRAD_STOPS [16][5] = '{
    '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0},
    '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0},
    '{{8'd0, 8'd255, 8'd0, 8'd128}, {8'd64, 8'd255, 8'd100, 8'd0},
      {8'd128, 8'd255, 8'd220, 8'd0}, {8'd192, 8'd180, 8'd0, 8'd255},
      {8'd255, 8'd255, 8'd0, 8'd128}},
    '{{8'd0, 8'd0, 8'd20, 8'd90}, {8'd80, 8'd0, 8'd90, 8'd160},
      {8'd160, 8'd0, 8'd170, 8'd190}, {8'd255, 8'd190, 8'd240, 8'd255}, 32'd0},
    '{{8'd0, 8'd0, 8'd40, 8'd10}, {8'd90, 8'd20, 8'd110, 8'd20},
      {8'd170, 8'd90, 8'd160, 8'd30}, {8'd255, 8'd200, 8'd220, 8'd90}, 32'd0},
    '{{8'd0, 8'd20, 8'd0, 8'd0}, {8'd90, 8'd160, 8'd20, 8'd0},
      {8'd180, 8'd255, 8'd110, 8'd0}, {8'd255, 8'd255, 8'd230, 8'd120}, 32'd0},
    '{{8'd0, 8'd0, 8'd0, 8'd80}, {8'd60, 8'd0, 8'd60, 8'd160},
      {8'd130, 8'd120, 8'd160, 8'd220}, {8'd200, 8'd220, 8'd235, 8'd255},
      {8'd255, 8'd255, 8'd255, 8'd255}},
    '{{8'd0, 8'd0, 8'd0, 8'd0}, {8'd64, 8'd140, 8'd0, 8'd0},
      {8'd128, 8'd220, 8'd60, 8'd0}, {8'd190, 8'd255, 8'd190, 8'd0},
      {8'd255, 8'd255, 8'd255, 8'd220}},
    '{{8'd0, 8'd60, 8'd10, 8'd60}, {8'd70, 8'd200, 8'd50, 8'd60},
      {8'd140, 8'd255, 8'd120, 8'd40}, {8'd200, 8'd255, 8'd190, 8'd90},
      {8'd255, 8'd255, 8'd235, 8'd180}},
    '{{8'd0, 8'd0, 8'd20, 8'd40}, {8'd70, 8'd0, 8'd140, 8'd110},
      {8'd140, 8'd40, 8'd220, 8'd150}, {8'd200, 8'd120, 8'd90, 8'd220},
      {8'd255, 8'd20, 8'd20, 8'd90}},
    '{{8'd0, 8'd0, 8'd10, 8'd60}, {8'd80, 8'd0, 8'd90, 8'd180},
      {8'd160, 8'd120, 8'd200, 8'd240}, {8'd255, 8'd255, 8'd255, 8'd255}, 32'd0},
    '{{8'd0, 8'd60, 8'd10, 8'd0}, {8'd90, 8'd180, 8'd60, 8'd0},
      {8'd170, 8'd255, 8'd140, 8'd30}, {8'd255, 8'd255, 8'd200, 8'd120}, 32'd0},
    '{{8'd0, 8'd60, 8'd15, 8'd0}, {8'd80, 8'd170, 8'd60, 8'd0},
      {8'd160, 8'd220, 8'd140, 8'd20}, {8'd220, 8'd200, 8'd90, 8'd10},
      {8'd255, 8'd120, 8'd30, 8'd0}},
    '{{8'd0, 8'd120, 8'd20, 8'd60}, {8'd80, 8'd255, 8'd120, 8'd180},
      {8'd160, 8'd255, 8'd190, 8'd215}, {8'd255, 8'd255, 8'd240, 8'd245}, 32'd0},
    '{{8'd0, 8'd0, 8'd255, 8'd200}, {8'd85, 8'd80, 8'd0, 8'd255},
      {8'd170, 8'd255, 8'd0, 8'd150}, {8'd255, 8'd0, 8'd255, 8'd200}, 32'd0},
    '{{8'd0, 8'd0, 8'd0, 8'd30}, {8'd90, 8'd0, 8'd40, 8'd110},
      {8'd170, 8'd0, 8'd120, 8'd150}, {8'd255, 8'd80, 8'd220, 8'd200}, 32'd0}
  };

  logic [7:0]  pal_sel;
  color_item_t primary;
  color_item_t expected_colors [$];
  int          err_cnt;

  function automatic logic [7:0] mix_channel(input logic [7:0] x, input logic [7:0] y,
                                             input int f);
    return 8'((int'(x) * (255 - f) + int'(y) * f) / 255);
  endfunction

  function automatic color_item_t predict_color(input logic [7:0] position);
    color_item_t c;
    stop_t       lo;
    stop_t       hi;
    int          hue;
    int          region;
    int          rem;
    int          q;
    int          t;
    int          pal;
    int          n;
    int          span;
    int          f;
    bit          found;
    c = primary;
    pal = pal_sel;
    hue = position;
    if (pal_sel == PAL_RAINBOW) begin
      region = hue / 43;
      rem = ((hue - region * 43) * 6) & 255;
      q = (255 * (255 - ((255 * rem) >> 8))) >> 8;
      t = (255 * (255 - ((255 * (255 - rem)) >> 8))) >> 8;
      case (region)
        HUE_R_TO_Y: c = '{red: 8'd255, green: 8'(t), blue: 8'd0};
        HUE_Y_TO_G: c = '{red: 8'(q), green: 8'd255, blue: 8'd0};
        HUE_G_TO_C: c = '{red: 8'd0, green: 8'd255, blue: 8'(t)};
        HUE_C_TO_B: c = '{red: 8'd0, green: 8'(q), blue: 8'd255};
        HUE_B_TO_M: c = '{red: 8'(t), green: 8'd0, blue: 8'd255};
        default:    c = '{red: 8'd255, green: 8'd0, blue: 8'(q)};
      endcase
    end else if (pal < PALETTE_COUNT && pal < 16 && GRAD_STOP_CNT[pal] != 0) begin
      n = GRAD_STOP_CNT[pal];
      // position past every pair falls back to the last stop
      lo = stop_t'(GRAD_STOPS[pal][n-1]);
      c = '{red: lo.r, green: lo.g, blue: lo.b};
      found = 1'b0;
      for (int i = 0; i + 1 < n; i++) begin
        lo = stop_t'(GRAD_STOPS[pal][i]);
        hi = stop_t'(GRAD_STOPS[pal][i+1]);
        if (!found && hue >= int'(lo.pos) && hue <= int'(hi.pos)) begin
          found = 1'b1;
          span = int'(hi.pos) - int'(lo.pos);
          if (span == 0) begin
            c = '{red: lo.r, green: lo.g, blue: lo.b};
          end else begin
            f = ((hue - int'(lo.pos)) * 255) / span;
            c = '{red: mix_channel(lo.r, hi.r, f), green: mix_channel(lo.g, hi.g, f),
                  blue: mix_channel(lo.b, hi.b, f)};
          end
        end
      end
    end
    return c;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    color_item_t want;
    if (!rst_ni) begin
      pal_sel = '0;
      primary = '0;
      expected_colors.delete();
      err_cnt = 0;
      pending_o <= 0;
      errors_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PALETTE_SELECT: pal_sel = cfg_wdata_i;
          CFG_PRIMARY_RED:    primary.red = cfg_wdata_i;
          CFG_PRIMARY_GREEN:  primary.green = cfg_wdata_i;
          CFG_PRIMARY_BLUE:   primary.blue = cfg_wdata_i;
          default: ;
        endcase
      end
      if (pos_valid_i && pos_ready_i) begin
        expected_colors.push_back(predict_color(pos_i.position));
      end
      if (color_valid_i && color_ready_i) begin
        if (expected_colors.size() == 0) begin
          $display("%0t: unexpected color item r=%0d g=%0d b=%0d", $time,
                   color_i.red, color_i.green, color_i.blue);
          err_cnt++;
        end else begin
          want = expected_colors.pop_front();
          if (color_i.red !== want.red || color_i.green !== want.green ||
              color_i.blue !== want.blue) begin
            $display("%0t: color mismatch, expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                     $time, want.red, want.green, want.blue,
                     color_i.red, color_i.green, color_i.blue);
            err_cnt++;
          end
        end
      end
      pending_o <= expected_colors.size();
      errors_o <= err_cnt;
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// tb_top: drives positions and palette settings into palette_gradient_color with
// random idling and back pressure; pgc_color_checker predicts and compares the colors
// depends on pgc_pkg, pgc_stream_if, palette_gradient_color and pgc_color_checker
`timescale 1ns / 100ps

module tb_top;
  import pgc_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_CYCLES = 200;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int PHASES       = 25;
  localparam int PHASE_ITEMS  = 52;
  localparam int PAL_COUNT    = 16;

  // index past the last register, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 4'hF;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  bit stall_req = 1'b0;
  bit tx_quiet  = 1'b0;
  bit rx_quiet  = 1'b0;
  int pending;
  int errors;
  int cycle_cnt = 0;

  pgc_stream_if #(.payload_t(pos_item_t))   pos_ch ();
  pgc_stream_if #(.payload_t(color_item_t)) color_ch ();

  palette_gradient_color #(
    .PALETTE_COUNT(PAL_COUNT),
    .MAX_STOPS    (5)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (pos_ch),
    .out_o      (color_ch)
  );

  pgc_color_checker #(
    .PALETTE_COUNT(PAL_COUNT)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .pos_valid_i  (pos_ch.valid),
    .pos_ready_i  (pos_ch.ready),
    .pos_i        (pos_ch.data),
    .color_valid_i(color_ch.valid),
    .color_ready_i(color_ch.ready),
    .color_i      (color_ch.data),
    .pending_o    (pending),
    .errors_o     (errors)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // color sink: random back pressure, plus one long hold-off on request
  initial begin
    color_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_req) begin
        color_ch.ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
        stall_req = 1'b0;
      end
      color_ch.ready <= rx_quiet || ($urandom_range(99) >= 13);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // drain the pipeline before touching the registers
  task automatic set_palette(input logic [7:0] pal, input logic [7:0] red,
                             input logic [7:0] grn, input logic [7:0] blu);
    pos_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(CFG_PALETTE_SELECT, pal);
    write_reg(CFG_PRIMARY_RED, red);
    write_reg(CFG_PRIMARY_GREEN, grn);
    write_reg(CFG_PRIMARY_BLUE, blu);
    write_reg(CFG_UNUSED_IDX, 8'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic send_position(input logic [7:0] position);
    if (!tx_quiet && $urandom_range(99) < 6) begin
      pos_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    pos_ch.valid <= 1'b1;
    pos_ch.data.position <= position;
    do @(posedge clk); while (!pos_ch.ready);
  endtask

  initial begin
    int         hues [12] = '{0, 42, 43, 85, 86, 128, 129, 171, 172, 214, 215, 255};
    int         grad_pos [6] = '{0, 64, 100, 192, 254, 255};
    logic [7:0] pal;
    logic [7:0] red;
    logic [7:0] grn;
    logic [7:0] blu;

    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= '0;
    cfg_wdata <= '0;
    pos_ch.valid <= 1'b0;
    pos_ch.data <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: primary colour, rainbow region edges, stop positions, unknown palettes
    set_palette(8'd0, 8'd255, 8'd255, 8'd255);
    send_position(8'd0);
    send_position(8'd255);
    set_palette(PAL_RAINBOW, 8'd0, 8'd0, 8'd0);
    foreach (hues[i]) send_position(8'(hues[i]));
    set_palette(8'd2, 8'd17, 8'd34, 8'd51);
    foreach (grad_pos[i]) send_position(8'(grad_pos[i]));
    set_palette(8'd12, 8'd1, 8'd2, 8'd3);
    send_position(8'd220);
    send_position(8'd221);
    set_palette(8'd255, 8'h00, 8'h80, 8'hFF);
    send_position(8'h5A);
    set_palette(8'(PAL_COUNT), 8'hFF, 8'h7F, 8'h01);
    send_position(8'hA5);

    for (int k = 0; k < PHASES; k++) begin
      if (k < PAL_COUNT) begin
        pal = 8'(k);
      end else if (k == PAL_COUNT) begin
        pal = 8'd255;
      end else if (k == PAL_COUNT + 1) begin
        pal = PAL_RAINBOW;
      end else if ($urandom_range(1) == 0) begin
        pal = 8'($urandom_range(PAL_COUNT - 1));
      end else begin
        pal = 8'($urandom_range(255, PAL_COUNT));
      end
      if (k % 5 == 0) begin
        {red, grn, blu} = {3{8'hFF}};
      end else if (k % 5 == 1) begin
        {red, grn, blu} = '0;
      end else begin
        {red, grn, blu} = 24'($urandom);
      end
      set_palette(pal, red, grn, blu);
      // one stretch with no idling on either side
      tx_quiet = (k == 9 || k == 10);
      rx_quiet = tx_quiet;
      if (k == 6) stall_req = 1'b1;
      repeat (PHASE_ITEMS) send_position(8'($urandom));
    end

    pos_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (2 * DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
